// File: sv/afd_pkg.sv
package afd_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int WORK_FRAC    = 30;
	localparam int DATA_W       = 32;
	localparam int ROT_W        = 19;
	localparam int SCALE_W      = 31;
	localparam int SQ_W         = 64;
	localparam int SQ_STEPS     = SQ_W / 2;
	localparam int STEP_W       = 5;
	localparam int DIV_W        = DATA_W + FRAC_BITS;
	localparam int QW           = FRAC_BITS + 1;
	localparam int NW           = FRAC_BITS + 2;
	localparam int XW           = 36;
	localparam int ZW           = 34;
	localparam int PRE_SH       = WORK_FRAC - FRAC_BITS;
	localparam int IN_W         = 12 * DATA_W;
	localparam int OUT_W        = ((3 * (DATA_W + ROT_W + SCALE_W) + 7) / 8) * 8;

	localparam logic signed [ZW-1:0] HALF_PI_W = 34'sd1686629713;
	localparam longint PI_W    = 64'd3373259426;
	localparam longint ROT_LIM = (PI_W + (64'd1 << (PRE_SH - 1))) >> PRE_SH;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] pos;
		logic [4:0][DATA_W-1:0] mg;
		logic [4:0]             sg;
	} side_a_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0]  pos;
		logic [4:0]              sg;
		logic [2:0][SCALE_W-1:0] scale;
	} side_b_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0]  pos;
		logic [2:0][SCALE_W-1:0] scale;
	} side_c_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0]  pos;
		logic [2:0][SCALE_W-1:0] scale;
		logic [4:0][NW-1:0]      n;
	} side_d_t;

	// atan(2^-i) with 30 fraction bits
	function automatic logic signed [ZW-1:0] atan_w(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			5'd24: r = 34'sd64;
			5'd25: r = 34'sd32;
			5'd26: r = 34'sd16;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			5'd30: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/afd_sqrt_cell.sv
module afd_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [afd_pkg::STEP_W-1:0]    step,
	input  logic [afd_pkg::SQ_W-1:0]      v_in,
	input  logic [afd_pkg::SQ_W-1:0]      r_in,
	output logic [afd_pkg::SQ_W-1:0]      v_out,
	output logic [afd_pkg::SQ_W-1:0]      r_out
);

	logic [5:0]                 sh;
	logic [afd_pkg::SQ_W-1:0]   b;
	logic [afd_pkg::SQ_W:0]     t;
	logic [afd_pkg::SQ_W-1:0]   v_q, r_q;

	always_comb begin
		sh = 6'(afd_pkg::SQ_W - 2) - {step, 1'b0};
		b  = afd_pkg::SQ_W'(1) << sh;
		t  = {1'b0, r_in} + {1'b0, b};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, v_in} >= t) begin
				v_q <= v_in - t[afd_pkg::SQ_W-1:0];
				r_q <= (r_in >> 1) + b;
			end else begin
				v_q <= v_in;
				r_q <= r_in >> 1;
			end
		end
	end

	assign v_out = v_q;
	assign r_out = r_q;

endmodule

// File: sv/afd_div_cell.sv
module afd_div_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [afd_pkg::STEP_W-1:0]    step,
	input  logic [afd_pkg::DIV_W-1:0]     rem_in,
	input  logic [afd_pkg::QW-1:0]        q_in,
	input  logic [afd_pkg::DATA_W-1:0]    d_in,
	output logic [afd_pkg::DIV_W-1:0]     rem_out,
	output logic [afd_pkg::QW-1:0]        q_out,
	output logic [afd_pkg::DATA_W-1:0]    d_out
);

	logic [afd_pkg::DIV_W:0]    ds;
	logic [afd_pkg::DIV_W-1:0]  rem_q;
	logic [afd_pkg::QW-1:0]     q_q;
	logic [afd_pkg::DATA_W-1:0] d_q;

	assign ds = (afd_pkg::DIV_W + 1)'(d_in) << step;

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_in;
			if ({1'b0, rem_in} >= ds) begin
				rem_q <= rem_in - ds[afd_pkg::DIV_W-1:0];
				q_q   <= q_in | (afd_pkg::QW'(1) << step);
			end else begin
				rem_q <= rem_in;
				q_q   <= q_in;
			end
		end
	end

	assign rem_out = rem_q;
	assign q_out   = q_q;
	assign d_out   = d_q;

endmodule

// File: sv/afd_cordic_cell.sv
module afd_cordic_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [afd_pkg::STEP_W-1:0]        step,
	input  logic signed [afd_pkg::XW-1:0]     x_in,
	input  logic signed [afd_pkg::XW-1:0]     y_in,
	input  logic signed [afd_pkg::ZW-1:0]     z_in,
	input  logic                              zf_in,
	output logic signed [afd_pkg::XW-1:0]     x_out,
	output logic signed [afd_pkg::XW-1:0]     y_out,
	output logic signed [afd_pkg::ZW-1:0]     z_out,
	output logic                              zf_out
);

	logic signed [afd_pkg::XW-1:0] dx, dy, x_q, y_q;
	logic signed [afd_pkg::ZW-1:0] a, z_q;
	logic                          zf_q;

	always_comb begin
		dx = y_in >>> step;
		dy = x_in >>> step;
		a  = afd_pkg::atan_w(step);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zf_q <= zf_in;
			if (y_in < 0) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - a;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + a;
			end
		end
	end

	assign x_out  = x_q;
	assign y_out  = y_q;
	assign z_out  = z_q;
	assign zf_out = zf_q;

endmodule

// File: sv/affine_matrix_trs_decompose.sv
// affine transform decomposition: translation, per-axis scale, xyz euler angles
// input stream s_*: one request per beat holds the upper three rows of a
// column-major 4x4 transform, twelve signed q16.16 words
// output stream m_*: one request per input with position (q16.16), rotation in
// radians (signed q3.16, 19 bits) and scale (unsigned q15.16, 31 bits)
// the block is a chain of small cells: 32 square-root cells per column for
// the column lengths, 17 restoring divider cells per lane for normalization,
// 32 more square-root cells for the pitch term and 18 cordic vectoring cells per angle
// throughput is one transform per cycle while the receiver keeps up; every cell advances one step a cycle
// when the output register is held by a stalled receiver the whole chain
// holds and s_tready drops in that cycle; nothing is lost or repeated
// reset clears the valid chain only; data registers keep stale values
module affine_matrix_trs_decompose (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// c0_x c0_y c0_z c1_x c1_y c1_z c2_x c2_y c2_z c3_x c3_y c3_z
	input  logic [afd_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pos_x pos_y pos_z rot_x rot_y rot_z scale_x scale_y scale_z, 2 zero pad bits
	output logic [afd_pkg::OUT_W-1:0]     m_tdata
);

	localparam int DW  = afd_pkg::DATA_W;
	localparam int SQS = afd_pkg::SQ_STEPS;
	localparam int QW  = afd_pkg::QW;
	localparam int NW  = afd_pkg::NW;
	localparam int CS  = afd_pkg::CORDIC_STEPS;
	localparam int XW  = afd_pkg::XW;
	localparam int ZW  = afd_pkg::ZW;
	localparam int LAT = 2 + SQS + QW + 2 + SQS + 1 + CS + 1;
	localparam logic signed [ZW-1:0] LIM_Z = ZW'(afd_pkg::ROT_LIM);
	localparam logic signed [ZW-1:0] RND_Z = ZW'(1) <<< (afd_pkg::PRE_SH - 1);

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + DW'(1)) : v;
	endfunction

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// squares of the column components
	logic [DW-1:0]             mg [9];
	logic [afd_pkg::SQ_W-1:0]  sq_s1 [9];
	afd_pkg::side_a_t          side_s1, side_s2;
	logic [afd_pkg::SQ_W-1:0]  sum_s2 [3];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			mg[k] = mag(s_tdata[k*DW +: DW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				sq_s1[k] <= afd_pkg::SQ_W'(mg[k]) * afd_pkg::SQ_W'(mg[k]);
			end
			for (int c = 0; c < 3; c++) begin
				side_s1.pos[c] <= s_tdata[(9+c)*DW +: DW];
			end
			side_s1.mg[0] <= mg[0];
			side_s1.mg[1] <= mg[1];
			side_s1.mg[2] <= mg[2];
			side_s1.mg[3] <= mg[5];
			side_s1.mg[4] <= mg[8];
			side_s1.sg    <= {s_tdata[9*DW-1], s_tdata[6*DW-1], s_tdata[3*DW-1],
				s_tdata[2*DW-1], s_tdata[DW-1]};
			for (int c = 0; c < 3; c++) begin
				sum_s2[c] <= sq_s1[3*c] + sq_s1[3*c+1] + sq_s1[3*c+2];
			end
			side_s2 <= side_s1;
		end
	end

	// column lengths
	logic [afd_pkg::SQ_W-1:0] sv [SQS+1][3];
	logic [afd_pkg::SQ_W-1:0] sr [SQS+1][3];
	afd_pkg::side_a_t         sa_d [SQS+1];

	assign sa_d[0] = side_s2;

	for (genvar c = 0; c < 3; c++) begin : g_len_in
		assign sv[0][c] = sum_s2[c];
		assign sr[0][c] = '0;
	end

	for (genvar k = 0; k < SQS; k++) begin : g_len
		for (genvar c = 0; c < 3; c++) begin : g_col
			afd_sqrt_cell u_cell (
				.clk   (clk),
				.en    (en),
				.step  (afd_pkg::STEP_W'(k)),
				.v_in  (sv[k][c]),
				.r_in  (sr[k][c]),
				.v_out (sv[k+1][c]),
				.r_out (sr[k+1][c])
			);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sa_d[k+1] <= sa_d[k];
			end
		end
	end

	// normalization
	logic [DW-1:0]             len [3];
	logic [afd_pkg::DIV_W-1:0] rm [QW+1][5];
	logic [QW-1:0]             qq [QW+1][5];
	logic [DW-1:0]             dd [QW+1][5];
	afd_pkg::side_b_t          sb_d [QW+1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			len[c] = sr[SQS][c][DW-1:0];
			sb_d[0].scale[c] = len[c][DW-1] ? {afd_pkg::SCALE_W{1'b1}}
				: len[c][afd_pkg::SCALE_W-1:0];
		end
		sb_d[0].pos = sa_d[SQS].pos;
		sb_d[0].sg  = sa_d[SQS].sg;
	end

	for (genvar l = 0; l < 5; l++) begin : g_div_in
		assign rm[0][l] = {sa_d[SQS].mg[l], {afd_pkg::FRAC_BITS{1'b0}}};
		assign qq[0][l] = '0;
		assign dd[0][l] = len[(l < 3) ? 0 : l - 2];
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		for (genvar l = 0; l < 5; l++) begin : g_lane
			afd_div_cell u_cell (
				.clk     (clk),
				.en      (en),
				.step    (afd_pkg::STEP_W'(afd_pkg::FRAC_BITS - k)),
				.rem_in  (rm[k][l]),
				.q_in    (qq[k][l]),
				.d_in    (dd[k][l]),
				.rem_out (rm[k+1][l]),
				.q_out   (qq[k+1][l]),
				.d_out   (dd[k+1][l])
			);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sb_d[k+1] <= sb_d[k];
			end
		end
	end

	// signed components and the pitch radicand
	logic [QW-1:0]       qm [5];
	logic [NW-1:0]       n_s3 [5];
	logic [2*QW-1:0]     rsq_s3 [2];
	afd_pkg::side_c_t    sc_s3;
	logic [2*QW:0]       rsum_s4;
	afd_pkg::side_d_t    sd_s4;

	always_comb begin
		for (int l = 0; l < 5; l++) begin
			qm[l] = (dd[QW][l] == '0) ? '0 : qq[QW][l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 5; l++) begin
				n_s3[l] <= sb_d[QW].sg[l] ? (~NW'(qm[l]) + NW'(1)) : NW'(qm[l]);
			end
			rsq_s3[0] <= (2*QW)'(qm[3]) * (2*QW)'(qm[3]);
			rsq_s3[1] <= (2*QW)'(qm[4]) * (2*QW)'(qm[4]);
			sc_s3.pos   <= sb_d[QW].pos;
			sc_s3.scale <= sb_d[QW].scale;
			rsum_s4     <= (2*QW+1)'(rsq_s3[0]) + (2*QW+1)'(rsq_s3[1]);
			sd_s4.pos   <= sc_s3.pos;
			sd_s4.scale <= sc_s3.scale;
			for (int l = 0; l < 5; l++) begin
				sd_s4.n[l] <= n_s3[l];
			end
		end
	end

	// pitch cosine term
	logic [afd_pkg::SQ_W-1:0] tv [SQS+1];
	logic [afd_pkg::SQ_W-1:0] tr [SQS+1];
	afd_pkg::side_d_t         sd_d [SQS+1];

	assign tv[0]   = afd_pkg::SQ_W'(rsum_s4);
	assign tr[0]   = '0;
	assign sd_d[0] = sd_s4;

	for (genvar k = 0; k < SQS; k++) begin : g_ry
		afd_sqrt_cell u_cell (
			.clk   (clk),
			.en    (en),
			.step  (afd_pkg::STEP_W'(k)),
			.v_in  (tv[k]),
			.r_in  (tr[k]),
			.v_out (tv[k+1]),
			.r_out (tr[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sd_d[k+1] <= sd_d[k];
			end
		end
	end

	// cordic setup: quadrant fold and scaling to the working format
	logic signed [NW-1:0] ay [3];
	logic signed [NW-1:0] ax [3];
	logic signed [XW-1:0] wx [3];
	logic signed [XW-1:0] wy [3];
	logic signed [XW-1:0] cx [CS+1][3];
	logic signed [XW-1:0] cy [CS+1][3];
	logic signed [ZW-1:0] cz [CS+1][3];
	logic                 zf [CS+1][3];
	afd_pkg::side_c_t     se_d [CS+1];

	always_comb begin
		ay[0] = $signed(sd_d[SQS].n[3]);
		ax[0] = $signed(sd_d[SQS].n[4]);
		ay[1] = -$signed(sd_d[SQS].n[2]);
		ax[1] = $signed(tr[SQS][NW-1:0]);
		ay[2] = $signed(sd_d[SQS].n[1]);
		ax[2] = $signed(sd_d[SQS].n[0]);
		for (int j = 0; j < 3; j++) begin
			wx[j] = XW'(ax[j]) <<< afd_pkg::PRE_SH;
			wy[j] = XW'(ay[j]) <<< afd_pkg::PRE_SH;
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_pre
		logic signed [XW-1:0] x_s5, y_s5;
		logic signed [ZW-1:0] z_s5;
		logic                 zf_s5;
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s5 <= (ax[j] == '0) && (ay[j] == '0);
				if (wx[j] < 0) begin
					if (wy[j] >= 0) begin
						x_s5 <= wy[j];
						y_s5 <= -wx[j];
						z_s5 <= afd_pkg::HALF_PI_W;
					end else begin
						x_s5 <= -wy[j];
						y_s5 <= wx[j];
						z_s5 <= -afd_pkg::HALF_PI_W;
					end
				end else begin
					x_s5 <= wx[j];
					y_s5 <= wy[j];
					z_s5 <= '0;
				end
			end
		end
		assign cx[0][j] = x_s5;
		assign cy[0][j] = y_s5;
		assign cz[0][j] = z_s5;
		assign zf[0][j] = zf_s5;
	end

	afd_pkg::side_c_t se_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			se_s5.pos   <= sd_d[SQS].pos;
			se_s5.scale <= sd_d[SQS].scale;
		end
	end

	assign se_d[0] = se_s5;

	for (genvar k = 0; k < CS; k++) begin : g_cordic
		for (genvar j = 0; j < 3; j++) begin : g_lane
			afd_cordic_cell u_cell (
				.clk    (clk),
				.en     (en),
				.step   (afd_pkg::STEP_W'(k)),
				.x_in   (cx[k][j]),
				.y_in   (cy[k][j]),
				.z_in   (cz[k][j]),
				.zf_in  (zf[k][j]),
				.x_out  (cx[k+1][j]),
				.y_out  (cy[k+1][j]),
				.z_out  (cz[k+1][j]),
				.zf_out (zf[k+1][j])
			);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				se_d[k+1] <= se_d[k];
			end
		end
	end

	// rounding, clamp and output register
	logic signed [ZW-1:0]        zr [3];
	logic [afd_pkg::ROT_W-1:0]   rot_s6 [3];
	afd_pkg::side_c_t            out_s6;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			zr[j] = (cz[CS][j] + RND_Z) >>> afd_pkg::PRE_SH;
			if (zr[j] > LIM_Z) begin
				zr[j] = LIM_Z;
			end else if (zr[j] < -LIM_Z) begin
				zr[j] = -LIM_Z;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				rot_s6[j] <= zf[CS][j] ? '0 : zr[j][afd_pkg::ROT_W-1:0];
			end
			out_s6 <= se_d[CS];
		end
	end

	assign m_tdata = afd_pkg::OUT_W'({out_s6.scale[2], out_s6.scale[1], out_s6.scale[0],
		rot_s6[2], rot_s6[1], rot_s6[0], out_s6.pos[2], out_s6.pos[1], out_s6.pos[0]});

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved during stall");

	a_rot_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(rot_s6[0]) <= $signed(LIM_Z[afd_pkg::ROT_W-1:0]))
			&& ($signed(rot_s6[0]) >= -$signed(LIM_Z[afd_pkg::ROT_W-1:0])))
		else $error("rot_x out of range");

	a_rot_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(rot_s6[2]) <= $signed(LIM_Z[afd_pkg::ROT_W-1:0]))
			&& ($signed(rot_s6[2]) >= -$signed(LIM_Z[afd_pkg::ROT_W-1:0])))
		else $error("rot_z out of range");

	a_rot_y_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(rot_s6[1]) <= $signed(LIM_Z[afd_pkg::ROT_W-1:0] >>> 1) + 64)
			&& ($signed(rot_s6[1]) >= -($signed(LIM_Z[afd_pkg::ROT_W-1:0] >>> 1) + 64)))
		else $error("rot_y beyond half turn");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;

	typedef struct packed {
		logic [2:0][afd_pkg::DATA_W-1:0]  pos;
		logic [2:0][afd_pkg::ROT_W-1:0]   rot;
		logic [2:0][afd_pkg::SCALE_W-1:0] scale;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [afd_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [afd_pkg::OUT_W-1:0] m_tdata;

	pose_t pose_q[$];
	int errors = 0;
	int sent = 0;
	int quiet = 0;

	affine_matrix_trs_decompose dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unit_comp(longint c, longint unsigned len);
		longint unsigned q;
		if (len == 0) return 0;
		q = (absv(c) << afd_pkg::FRAC_BITS) / len;
		return c < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint angle(longint y, longint x);
		longint z, t, dx, dy, lim;
		if (x == 0 && y == 0) return 0;
		x = x <<< afd_pkg::PRE_SH;
		y = y <<< afd_pkg::PRE_SH;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = afd_pkg::HALF_PI_W;
			end else begin
				t = x; x = -y; y = t; z = -afd_pkg::HALF_PI_W;
			end
		end
		for (int i = 0; i < afd_pkg::CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x -= dx; y += dy; z -= afd_pkg::atan_w(afd_pkg::STEP_W'(i));
			end else begin
				x += dx; y -= dy; z += afd_pkg::atan_w(afd_pkg::STEP_W'(i));
			end
		end
		z = (z + (64'sd1 <<< (afd_pkg::PRE_SH - 1))) >>> afd_pkg::PRE_SH;
		lim = afd_pkg::ROT_LIM;
		if (z > lim) z = lim;
		if (z < -lim) z = -lim;
		return z;
	endfunction

	function automatic pose_t decompose(logic [afd_pkg::IN_W-1:0] m);
		longint v[12];
		longint unsigned len[3];
		longint n0x, n0y, n0z, n1z, n2z, pitch_x;
		longint rz[3];
		pose_t p;
		for (int k = 0; k < 12; k++)
			v[k] = longint'($signed(m[k*afd_pkg::DATA_W +: afd_pkg::DATA_W]));
		for (int k = 0; k < 3; k++)
			len[k] = isqrt(absv(v[3*k])*absv(v[3*k]) + absv(v[3*k+1])*absv(v[3*k+1])
				+ absv(v[3*k+2])*absv(v[3*k+2]));
		n0x = unit_comp(v[0], len[0]);
		n0y = unit_comp(v[1], len[0]);
		n0z = unit_comp(v[2], len[0]);
		n1z = unit_comp(v[5], len[1]);
		n2z = unit_comp(v[8], len[2]);
		pitch_x = isqrt(absv(n1z)*absv(n1z) + absv(n2z)*absv(n2z));
		for (int k = 0; k < 3; k++) begin
			p.pos[k] = v[9+k][afd_pkg::DATA_W-1:0];
			p.scale[k] = (len[k] > 64'd2147483647) ? {afd_pkg::SCALE_W{1'b1}}
				: len[k][afd_pkg::SCALE_W-1:0];
		end
		rz[0] = angle(n1z, n2z);
		rz[1] = angle(-n0z, pitch_x);
		rz[2] = angle(n0y, n0x);
		for (int k = 0; k < 3; k++) p.rot[k] = rz[k][afd_pkg::ROT_W-1:0];
		return p;
	endfunction

	function automatic pose_t unpack_pose(logic [afd_pkg::OUT_W-1:0] d);
		pose_t p;
		for (int k = 0; k < 3; k++) begin
			p.pos[k] = d[k*afd_pkg::DATA_W +: afd_pkg::DATA_W];
			p.rot[k] = d[3*afd_pkg::DATA_W + k*afd_pkg::ROT_W +: afd_pkg::ROT_W];
			p.scale[k] = d[3*(afd_pkg::DATA_W+afd_pkg::ROT_W) + k*afd_pkg::SCALE_W
				+: afd_pkg::SCALE_W];
		end
		return p;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// output check and receiver stalls
	always @(posedge clk) begin
		pose_t got, want;
		if (m_tvalid && m_tready) begin
			got = unpack_pose(m_tdata);
			if (pose_q.size() == 0) begin
				report("unexpected request", 0, 0);
			end else begin
				want = pose_q.pop_front();
				for (int k = 0; k < 3; k++) begin
					if (got.pos[k] !== want.pos[k]) report($sformatf("pos[%0d]", k),
						longint'(got.pos[k]), longint'(want.pos[k]));
					if (got.rot[k] !== want.rot[k]) report($sformatf("rot[%0d]", k),
						longint'(got.rot[k]), longint'(want.rot[k]));
					if (got.scale[k] !== want.scale[k]) report($sformatf("scale[%0d]", k),
						longint'(got.scale[k]), longint'(want.scale[k]));
				end
			end
		end
		if (s_tvalid && s_tready) pose_q.push_back(decompose(s_tdata));
	end

	initial begin
		forever begin
			@(negedge clk);
			if (quiet > 0) begin
				quiet--;
				m_tready <= 1'b0;
			end else if (sent < 850 && $urandom_range(0, 15) == 0) begin
				quiet = $urandom_range(1, 19);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [afd_pkg::DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
			4: return 32'($signed($urandom_range(0, 262144)) - 131072);
			5: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic [afd_pkg::IN_W-1:0] m);
		s_tdata <= m;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic gap();
		int n;
		if (sent < 850 && $urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic [afd_pkg::IN_W-1:0] mat(logic [11:0][afd_pkg::DATA_W-1:0] w);
		return w;
	endfunction

	localparam logic [afd_pkg::DATA_W-1:0] ONE = 32'h0001_0000;
	localparam logic [afd_pkg::DATA_W-1:0] MONE = 32'hffff_0000;
	localparam logic [afd_pkg::DATA_W-1:0] MAXW = 32'h7fff_ffff;
	localparam logic [afd_pkg::DATA_W-1:0] MINW = 32'h8000_0000;

	// directed stimulus, words listed c3_z down to c0_x
	logic [11:0][afd_pkg::DATA_W-1:0] dir_tab[] = '{
		'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{MINW, MAXW, MINW, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{MAXW, MINW, MAXW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW},
		'{1, 2, 3, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW},
		'{0, 0, 0, MONE, 0, 0, 0, MONE, 0, 0, 0, MONE},
		'{0, 0, 0, 0, 0, ONE, 0, ONE, 0, MONE, 0, 0},
		'{0, 0, 0, 0, MONE, 0, ONE, 0, 0, 0, 0, ONE},
		'{0, 0, 0, MONE, 0, 0, 0, 0, 0, 0, MONE, 0},
		'{0, 0, 0, 0, 0, MONE, 0, 0, 0, ONE, 0, 0},
		'{0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, MONE},
		'{0, 0, 0, 0, 0, 0, 0, MONE, 0, 0, MONE, 0},
		'{5, 6, 7, 0, 0, MONE, 0, ONE, ONE, MONE, MONE, MONE},
		'{0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1},
		'{0, 0, 0, MONE, 0, 0, 0, MONE, 0, 0, 0, MONE},
		'{0, 0, 0, MAXW, 0, 0, MINW, 0, 0, 0, MINW, MAXW}
	};

	initial begin
		logic [11:0][afd_pkg::DATA_W-1:0] w;
		pose_t ident;
		int waited;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// identity: rotation zero, scale one, translation zero
		ident = '0;
		for (int k = 0; k < 3; k++) ident.scale[k] = ONE[afd_pkg::SCALE_W-1:0];
		if (decompose(mat(dir_tab[0])) !== ident) report("identity predictor", 0, 0);
		foreach (dir_tab[i]) begin
			send(mat(dir_tab[i]));
			gap();
		end
		for (int i = 0; i < 950; i++) begin
			for (int k = 0; k < 12; k++) w[k] = rand_word();
			if ($urandom_range(0, 3) == 0) begin
				w[$urandom_range(0, 2)] = 0;
				w[3 + $urandom_range(0, 2)] = 0;
			end
			send(mat(w));
			gap();
		end
		s_tvalid <= 1'b0;
		waited = 0;
		while (pose_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (150) @(posedge clk);
		if (pose_q.size() != 0) report("requests left over", pose_q.size(), 0);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
